[hw/rtl/afba_pkg.sv]
package afba_pkg;

  // Command codes carried in the request.
  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_EXPAND = 2'd1;
  localparam logic [1:0] CMD_FREE   = 2'd2;

  // Status codes returned in the response.
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_SIZE    = 2'd1;
  localparam logic [1:0] STAT_NOSPACE = 2'd2;

  // Width of the length and size fields of a request.
  localparam int LEN_W = 6;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [LEN_W-1:0] field_len;
    logic [LEN_W-1:0] addr_size;
    logic [LEN_W-1:0] old_field_len;
  } afba_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] field_mask;
    logic [4:0]  field_shift;
  } afba_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } afba_state_t;

endpackage

[hw/rtl/address_field_bit_allocator_top.sv]
// A request is accepted at an edge with start high and busy low; its response strobes
// out_valid once the request has been checked and, where it needs one, the one-bit-per-cycle
// scan of the occupancy map, over at most the address bits up to the current size, is done.
// One request at a time; busy drops the cycle after the response strobe.
// Reset: synchronous active-low rst_n clears the map, the address size and the sequencer.
// The receiver cannot stall: each response is valid for exactly one cycle.
module address_field_bit_allocator_top #(
  parameter int MAX_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  afba_pkg::afba_req_t in_req,
  output logic                busy,
  output logic                out_valid,
  output afba_pkg::afba_rsp_t out_rsp
);

  // SW holds a size or a scan position including the value MAX_BITS itself;
  // IW indexes one bit of the map.
  localparam int SW = $clog2(MAX_BITS + 1);
  localparam int IW = $clog2(MAX_BITS);
  localparam int LW = afba_pkg::LEN_W;
  localparam logic [LW:0] MAX_EXT = (LW + 1)'(MAX_BITS);

  afba_pkg::afba_state_t state_r, state_nxt;

  logic [MAX_BITS-1:0] map_r, map_nxt;
  logic [SW-1:0]       size_r, size_nxt;
  logic [SW-1:0]       pos_r, pos_nxt;
  // The run counter counts free bits while searching and cleared bits while freeing.
  logic [LW-1:0]       run_r, run_nxt;
  logic [IW-1:0]       base_r, base_nxt;
  afba_pkg::afba_req_t req_r, req_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                ok_r, ok_nxt;

  // Size check: the requested size is clamped to MAX_BITS before comparing.
  logic [LW:0]   req_ext;
  logic [LW:0]   req_clamp;
  logic [SW-1:0] req_size;
  logic          grow;
  logic          size_zero;
  logic          len_zero;
  logic          size_refused;

  always_comb begin
    req_ext      = {1'b0, req_r.addr_size};
    req_clamp    = (req_ext > MAX_EXT) ? MAX_EXT : req_ext;
    req_size     = SW'(req_clamp);
    grow         = (req_clamp > (LW + 1)'(size_r));
    size_zero    = (size_r == '0);
    len_zero     = (req_r.field_len == '0);
    size_refused = grow && !size_zero;
  end

  // The shared scan unit looks at one map bit per cycle. Searching walks down from the
  // top of the address and tracks the length of the current free run; the first run that
  // reaches the requested length is the highest window. Freeing walks up from bit zero.
  logic [SW-1:0] idx_dn;
  logic          bit_dn;
  logic          bit_up;
  logic [LW-1:0] run_inc;
  logic          hit;
  logic          scan_end;
  logic          free_end;

  always_comb begin
    idx_dn   = pos_r - SW'(1);
    bit_dn   = map_r[idx_dn[IW-1:0]];
    bit_up   = map_r[pos_r[IW-1:0]];
    run_inc  = run_r + LW'(1);
    hit      = !bit_dn && (run_inc == req_r.field_len);
    scan_end = (pos_r == '0);
    free_end = (pos_r == size_r) || (run_r == req_r.field_len);
  end

  // Ones of the allocated length, shifted into place when the window is marked.
  logic [MAX_BITS-1:0] mark_ones;

  afba_mask_gen #(
    .W  (MAX_BITS),
    .NW (LW + 1)
  ) u_mark_mask (
    .n    ({1'b0, req_r.field_len}),
    .mask (mark_ones)
  );

  // Response mask width: expand-port adds the old port field length.
  logic [LW:0]  out_width;
  logic [31:0]  out_mask;

  always_comb begin
    if (req_r.cmd == afba_pkg::CMD_EXPAND) begin
      out_width = {1'b0, req_r.field_len} + {1'b0, req_r.old_field_len};
    end else begin
      out_width = {1'b0, req_r.field_len};
    end
  end

  afba_mask_gen #(
    .W  (32),
    .NW (LW + 1)
  ) u_out_mask (
    .n    (out_width),
    .mask (out_mask)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      afba_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = afba_pkg::ST_CHECK;
        end
      end
      afba_pkg::ST_CHECK: begin
        if ((req_r.cmd == afba_pkg::CMD_ALLOC) || (req_r.cmd == afba_pkg::CMD_EXPAND)) begin
          if (size_refused || len_zero) begin
            state_nxt = afba_pkg::ST_DONE;
          end else begin
            state_nxt = afba_pkg::ST_SEARCH;
          end
        end else if (req_r.cmd == afba_pkg::CMD_FREE) begin
          state_nxt = afba_pkg::ST_FREE;
        end else begin
          state_nxt = afba_pkg::ST_DONE;
        end
      end
      afba_pkg::ST_SEARCH: begin
        if (scan_end) begin
          state_nxt = afba_pkg::ST_DONE;
        end else if (hit) begin
          state_nxt = afba_pkg::ST_MARK;
        end
      end
      afba_pkg::ST_MARK: begin
        state_nxt = afba_pkg::ST_DONE;
      end
      afba_pkg::ST_FREE: begin
        if (free_end) begin
          state_nxt = afba_pkg::ST_DONE;
        end
      end
      afba_pkg::ST_DONE: begin
        state_nxt = afba_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = afba_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    map_nxt    = map_r;
    size_nxt   = size_r;
    pos_nxt    = pos_r;
    run_nxt    = run_r;
    base_nxt   = base_r;
    req_nxt    = req_r;
    status_nxt = status_r;
    ok_nxt     = ok_r;
    case (state_r)
      afba_pkg::ST_IDLE: begin
        if (start) begin
          req_nxt    = in_req;
          status_nxt = afba_pkg::STAT_OK;
          ok_nxt     = 1'b0;
          base_nxt   = '0;
        end
      end
      afba_pkg::ST_CHECK: begin
        run_nxt = '0;
        if ((req_r.cmd == afba_pkg::CMD_ALLOC) || (req_r.cmd == afba_pkg::CMD_EXPAND)) begin
          pos_nxt = size_r;
          if (size_refused) begin
            status_nxt = afba_pkg::STAT_SIZE;
          end else begin
            // The first sizing request fixes the address size and starts a fresh map.
            if (grow) begin
              size_nxt = req_size;
              map_nxt  = '0;
              pos_nxt  = req_size;
            end
            if (len_zero) begin
              status_nxt = afba_pkg::STAT_NOSPACE;
            end
          end
        end else begin
          pos_nxt = '0;
        end
      end
      afba_pkg::ST_SEARCH: begin
        if (scan_end) begin
          status_nxt = afba_pkg::STAT_NOSPACE;
        end else begin
          run_nxt = bit_dn ? '0 : run_inc;
          pos_nxt = idx_dn;
          if (hit) begin
            base_nxt = idx_dn[IW-1:0];
          end
        end
      end
      afba_pkg::ST_MARK: begin
        map_nxt = map_r | (mark_ones << base_r);
        ok_nxt  = 1'b1;
      end
      afba_pkg::ST_FREE: begin
        if (!free_end) begin
          pos_nxt = pos_r + SW'(1);
          if (bit_up) begin
            map_nxt[pos_r[IW-1:0]] = 1'b0;
            run_nxt                = run_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= afba_pkg::ST_IDLE;
      map_r   <= '0;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      map_r   <= map_nxt;
      size_r  <= size_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    run_r    <= run_nxt;
    base_r   <= base_nxt;
    req_r    <= req_nxt;
    status_r <= status_nxt;
    ok_r     <= ok_nxt;
  end

  // Outputs. Error and free responses carry a zero mask and a zero shift.
  always_comb begin
    busy                = (state_r != afba_pkg::ST_IDLE);
    out_valid           = (state_r == afba_pkg::ST_DONE);
    out_rsp.status      = status_r;
    out_rsp.field_mask  = ok_r ? out_mask : '0;
    out_rsp.field_shift = ok_r ? 5'(base_r) : '0;
  end

  // A response is always part of a request in flight.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> busy)
    else $error("response strobe while idle");

  // An accepted request makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // The strobe lasts exactly one cycle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("response strobe longer than one cycle");

  // A successful allocation always reports a nonempty mask with status ok.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ok_r) |-> ((out_rsp.field_mask != '0) &&
                             (out_rsp.status == afba_pkg::STAT_OK)))
    else $error("allocation response with empty mask or bad status");

endmodule

[hw/rtl/afba_mask_gen.sv]
// Builds a word whose low n bits are ones; saturates to all ones when n >= W.
module afba_mask_gen #(
  parameter int W  = 32,
  parameter int NW = 7
) (
  input  logic [NW-1:0] n,
  output logic [W-1:0]  mask
);

  always_comb begin
    for (int i = 0; i < W; i++) begin
      mask[i] = (n > NW'(i));
    end
  end

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int MAX_BITS = 32;

  // Code 3 has no meaning to the block; it must answer with an all-zero OK response.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // The bound below leaves several times the worst case of a full scan plus the longest
  // sender gap for each of the 425 requests.
  localparam int CYCLE_LIMIT = 200000;

  localparam int RANDOM_REQUESTS = 400;

  // One row of the directed table. When has_literal is set the response is typed in
  // by hand; otherwise the allocation predictor supplies it.
  typedef struct {
    afba_pkg::afba_req_t req;
    bit                  has_literal;
    afba_pkg::afba_rsp_t rsp;
  } alloc_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  afba_pkg::afba_req_t in_req = '0;
  logic                busy;
  logic                out_valid;
  afba_pkg::afba_rsp_t out_rsp;

  // Predictor state: which address bits are handed out and the address size in bits.
  // The size is fixed by the first allocate or expand-port request with a nonzero size and
  // never changes afterwards, since reset is applied only once.
  logic [31:0]  occ_map = '0;
  int           addr_bits = 0;

  afba_pkg::afba_rsp_t pending_grants[$];
  alloc_row_t          alloc_table[$];
  int                  fail_count = 0;
  int                  cycle_count = 0;

  address_field_bit_allocator_top #(
    .MAX_BITS(MAX_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_req   (in_req),
    .busy     (busy),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always #6 clk = ~clk;

  // Works out the response to one request and advances the predictor state.
  function automatic afba_pkg::afba_rsp_t grant_for(input afba_pkg::afba_req_t r);
    afba_pkg::afba_rsp_t g;
    int                  len;
    int                  want;
    int                  width;
    int                  cleared;
    int                  p;
    int                  i;
    bit                  found;
    logic [63:0]         win;
    g = '0;
    len = int'(r.field_len);
    want = int'(r.addr_size);
    found = 1'b0;
    if (r.cmd == afba_pkg::CMD_ALLOC || r.cmd == afba_pkg::CMD_EXPAND) begin
      if (want > MAX_BITS) begin
        want = MAX_BITS;
      end
      // The first sizing request sets the size; any later larger one is refused.
      if (want > addr_bits) begin
        if (addr_bits == 0) begin
          addr_bits = want;
          occ_map = '0;
        end else begin
          g.status = afba_pkg::STAT_SIZE;
        end
      end
      if (g.status == afba_pkg::STAT_OK) begin
        // Scan from the top of the address downward for the first free window.
        if (len != 0 && len <= addr_bits) begin
          for (p = addr_bits; p >= len && !found; p--) begin
            win = ((64'd1 << len) - 64'd1) << (p - len);
            if ((win[31:0] & occ_map) == '0) begin
              found = 1'b1;
              occ_map = occ_map | win[31:0];
              g.field_shift = 5'(p - len);
            end
          end
        end
        if (!found) begin
          g.status = afba_pkg::STAT_NOSPACE;
        end else begin
          width = (r.cmd == afba_pkg::CMD_ALLOC) ? len : len + int'(r.old_field_len);
          g.field_mask = (width >= 32) ? '1 : (32'd1 << width) - 32'd1;
        end
      end
    end else if (r.cmd == afba_pkg::CMD_FREE) begin
      // Release the lowest used bits first, at most field_len of them.
      cleared = 0;
      for (i = 0; i < addr_bits; i++) begin
        if (occ_map[i] && cleared < len) begin
          occ_map[i] = 1'b0;
          cleared++;
        end
      end
    end
    return g;
  endfunction

  // Random request biased toward well-formed traffic: sizes that fit the address,
  // short fields, and enough frees to keep the map from filling for good.
  function automatic afba_pkg::afba_req_t random_request();
    afba_pkg::afba_req_t r;
    int                  sel;
    sel = $urandom_range(0, 99);
    r.old_field_len = 6'($urandom_range(0, 63));
    if ($urandom_range(0, 9) == 0) begin
      r.addr_size = 6'($urandom_range(32, 63));
    end else begin
      r.addr_size = 6'($urandom_range(0, 31));
    end
    if (sel < 40) begin
      r.cmd = afba_pkg::CMD_ALLOC;
    end else if (sel < 65) begin
      r.cmd = afba_pkg::CMD_EXPAND;
    end else if (sel < 95) begin
      r.cmd = afba_pkg::CMD_FREE;
    end else begin
      r.cmd = CMD_UNUSED;
    end
    if ($urandom_range(0, 9) == 0) begin
      r.field_len = 6'($urandom_range(0, 63));
    end else if (r.cmd == afba_pkg::CMD_FREE) begin
      r.field_len = 6'($urandom_range(1, 16));
    end else begin
      r.field_len = 6'($urandom_range(1, 10));
    end
    return r;
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 50);
  endfunction

  task automatic add_row(input logic [1:0] cmd, input int len, input int size, input int old,
                         input bit has_literal, input logic [1:0] status,
                         input logic [31:0] mask, input int shift);
    alloc_row_t row;
    row.req.cmd = cmd;
    row.req.field_len = 6'(len);
    row.req.addr_size = 6'(size);
    row.req.old_field_len = 6'(old);
    row.has_literal = has_literal;
    row.rsp.status = status;
    row.rsp.field_mask = mask;
    row.rsp.field_shift = 5'(shift);
    alloc_table.push_back(row);
  endtask

  // Presents one request and holds it until the block takes it. The call starts and
  // ends on a rising edge. With a zero gap start stays high so the next request can
  // follow at once; otherwise start drops at the accepting edge.
  task automatic issue(input afba_pkg::afba_req_t r, input bit has_literal,
                       input afba_pkg::afba_rsp_t lit, input int gap);
    afba_pkg::afba_rsp_t g;
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    g = grant_for(r);
    pending_grants.push_back(has_literal ? lit : g);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Response checker. Values are read at the edge that ends the strobe cycle, so they
  // are the ones the block drove during that cycle.
  always @(posedge clk) begin
    afba_pkg::afba_rsp_t want;
    if (rst_n && out_valid) begin
      if (pending_grants.size() == 0) begin
        $error("unexpected response: status %0d mask %h shift %0d",
               out_rsp.status, out_rsp.field_mask, out_rsp.field_shift);
        fail_count++;
      end else begin
        want = pending_grants.pop_front();
        if (out_rsp.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp.status);
          fail_count++;
        end
        if (out_rsp.field_mask !== want.field_mask) begin
          $error("field_mask: expected %h, got %h", want.field_mask, out_rsp.field_mask);
          fail_count++;
        end
        if (out_rsp.field_shift !== want.field_shift) begin
          $error("field_shift: expected %0d, got %0d", want.field_shift, out_rsp.field_shift);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    afba_pkg::afba_req_t r;
    afba_pkg::afba_rsp_t none;
    int                  n;
    none = '0;

    // Directed table. The address size is set to 31 bits so that a request for
    // 32 bits or more is refused, while the map still spans almost the whole word.
    // Free before any size is set: nothing to release, plain OK.
    add_row(afba_pkg::CMD_FREE,    5,  0,  0, 1, afba_pkg::STAT_OK,      32'h0,        0);
    // Zero length and no size yet: no space.
    add_row(afba_pkg::CMD_ALLOC,   0,  0,  0, 1, afba_pkg::STAT_NOSPACE, 32'h0,        0);
    // Nonzero length but the size is still zero: no space.
    add_row(afba_pkg::CMD_ALLOC,   4,  0,  0, 1, afba_pkg::STAT_NOSPACE, 32'h0,        0);
    // Expand-port fixes the size at 31 even though its zero length fails.
    add_row(afba_pkg::CMD_EXPAND,  0, 31,  0, 1, afba_pkg::STAT_NOSPACE, 32'h0,        0);
    // First field lands at the top of the 31-bit address.
    add_row(afba_pkg::CMD_ALLOC,   8, 31,  0, 1, afba_pkg::STAT_OK,      32'hFF,       23);
    // Larger size than the one fixed: refused, also with the request clamped to 32.
    add_row(afba_pkg::CMD_ALLOC,   1, 32,  0, 1, afba_pkg::STAT_SIZE,    32'h0,        0);
    add_row(afba_pkg::CMD_ALLOC,   1, 63,  0, 1, afba_pkg::STAT_SIZE,    32'h0,        0);
    // Expand-port mask covers the new and the old field.
    add_row(afba_pkg::CMD_EXPAND,  4,  1,  4, 1, afba_pkg::STAT_OK,      32'hFF,       19);
    // Longer than the address: no space.
    add_row(afba_pkg::CMD_ALLOC,  32, 31,  0, 1, afba_pkg::STAT_NOSPACE, 32'h0,        0);
    // Fills the rest of the map; the combined width saturates the mask.
    add_row(afba_pkg::CMD_EXPAND, 19, 31, 32, 1, afba_pkg::STAT_OK,      32'hFFFFFFFF, 0);
    // Map full.
    add_row(afba_pkg::CMD_ALLOC,   1,  0,  0, 1, afba_pkg::STAT_NOSPACE, 32'h0,        0);
    add_row(afba_pkg::CMD_FREE,    3,  0,  0, 1, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_ALLOC,   2,  5,  0, 1, afba_pkg::STAT_OK,      32'h3,        1);
    // Free longer than the number of used bits clears them all.
    add_row(afba_pkg::CMD_FREE,   63,  0,  0, 1, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_ALLOC,  31, 31,  0, 1, afba_pkg::STAT_OK,      32'h7FFFFFFF, 0);
    // Zero-length free releases nothing, so the next allocate finds no room.
    add_row(afba_pkg::CMD_FREE,    0,  0,  0, 1, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_ALLOC,   1,  0,  0, 1, afba_pkg::STAT_NOSPACE, 32'h0,        0);
    add_row(afba_pkg::CMD_FREE,    1,  0,  0, 1, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_EXPAND,  1,  0, 63, 1, afba_pkg::STAT_OK,      32'hFFFFFFFF, 0);
    // Unused command code with every field at its top value.
    add_row(CMD_UNUSED,           63, 63, 63, 1, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_FREE,   32,  0,  0, 1, afba_pkg::STAT_OK,      32'h0,        0);
    // Combined width of exactly 32 bits.
    add_row(afba_pkg::CMD_EXPAND, 31, 31,  1, 1, afba_pkg::STAT_OK,      32'hFFFFFFFF, 0);
    add_row(afba_pkg::CMD_FREE,   16,  0,  0, 0, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_ALLOC,  16,  3,  0, 0, afba_pkg::STAT_OK,      32'h0,        0);
    add_row(afba_pkg::CMD_FREE,   40,  0,  0, 0, afba_pkg::STAT_OK,      32'h0,        0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (alloc_table[k]) begin
      issue(alloc_table[k].req, alloc_table[k].has_literal, alloc_table[k].rsp, sender_gap());
    end

    // Let the directed part drain completely before random traffic starts.
    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);

    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      r = random_request();
      // A stretch of back-to-back requests, then a full drain part way through.
      issue(r, 1'b0, none, (n >= 150 && n < 200) ? 0 : sender_gap());
      if (n == 250) begin
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    // Give a stray late response time to show up.
    repeat (MAX_BITS + 8) @(posedge clk);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
